// ----- rtl/bcdas_pkg.sv -----
// ---------------------------------------------------------------------------
// bcdas_pkg
// Shared types, constants and helpers for the signed BCD add/subtract core.
// ---------------------------------------------------------------------------
package bcdas_pkg;

    localparam int DIGITS      = 16;
    localparam int DIGIT_W     = 4;
    localparam int DATA_W      = 64;
    localparam int PREFIX_LVLS = (DIGITS > 1) ? $clog2(DIGITS) : 0;

    localparam logic [DIGIT_W-1:0] DEC_MAX   = 4'd9;
    localparam logic [DIGIT_W:0]   DEC_RADIX = 5'd10;

    typedef enum logic
    {
        CMD_ADD = 1'b0,
        CMD_SUB = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t              cmd;
        logic [DATA_W-1:0] a_digits;
        logic              a_negative;
        logic [DATA_W-1:0] b_digits;
        logic              b_negative;
    } req_t;

    typedef struct packed
    {
        logic [DATA_W-1:0] result_digits;
        logic              result_negative;
        logic              overflow;
    } rsp_t;

    // Carry/borrow generate and propagate per digit
    typedef struct packed
    {
        logic [DIGITS-1:0] gen;
        logic [DIGITS-1:0] prop;
    } gp_t;

    function automatic logic [DIGIT_W-1:0] bcd_clamp(input logic [DIGIT_W-1:0] n);
        return (n > DEC_MAX) ? DEC_MAX : n;
    endfunction

endpackage

// ----- rtl/bcdas_prefix.sv -----
// ---------------------------------------------------------------------------
// bcdas_prefix
// Parallel-prefix carry network over decimal digits (carry-in is zero).
// ---------------------------------------------------------------------------
module bcdas_prefix
(
    input  bcdas_pkg::gp_t                gp,
    output logic [bcdas_pkg::DIGITS:0]    carry
);

    logic [bcdas_pkg::DIGITS-1:0] gk;
    logic [bcdas_pkg::DIGITS-1:0] pk;
    logic [bcdas_pkg::DIGITS-1:0] gn;
    logic [bcdas_pkg::DIGITS-1:0] pn;

    always_comb
    begin
        gk = gp.gen;
        pk = gp.prop;
        gn = gp.gen;
        pn = gp.prop;
        for (int l = 0; l < bcdas_pkg::PREFIX_LVLS; l++)
        begin
            for (int i = 0; i < bcdas_pkg::DIGITS; i++)
            begin
                if (i >= (1 << l))
                begin
                    gn[i] = gk[i] | (pk[i] & gk[i - (1 << l)]);
                    pn[i] = pk[i] & pk[i - (1 << l)];
                end
                else
                begin
                    gn[i] = gk[i];
                    pn[i] = pk[i];
                end
            end
            gk = gn;
            pk = pn;
        end
        carry = {gk, 1'b0};
    end

endmodule

// ----- rtl/bcdas_datapath.sv -----
// ---------------------------------------------------------------------------
// bcdas_datapath
// Single-pass sign-magnitude decimal add/subtract with lookahead carries.
// ---------------------------------------------------------------------------
module bcdas_datapath
(
    input  bcdas_pkg::req_t req,
    output bcdas_pkg::rsp_t rsp
);

    logic [bcdas_pkg::DIGIT_W-1:0] da [bcdas_pkg::DIGITS];
    logic [bcdas_pkg::DIGIT_W-1:0] db [bcdas_pkg::DIGITS];
    logic [bcdas_pkg::DIGIT_W:0]   dsum [bcdas_pkg::DIGITS];

    bcdas_pkg::gp_t add_gp;
    bcdas_pkg::gp_t ab_gp;
    bcdas_pkg::gp_t ba_gp;

    logic [bcdas_pkg::DIGITS:0] add_c;
    logic [bcdas_pkg::DIGITS:0] ab_b;
    logic [bcdas_pkg::DIGITS:0] ba_b;

    logic [bcdas_pkg::DATA_W-1:0] add_r;
    logic [bcdas_pkg::DATA_W-1:0] ab_r;
    logic [bcdas_pkg::DATA_W-1:0] ba_r;

    logic b_neg_eff;
    logic a_lt_b;

    always_comb
    begin
        for (int i = 0; i < bcdas_pkg::DIGITS; i++)
        begin
            da[i] = bcdas_pkg::bcd_clamp(req.a_digits[i*bcdas_pkg::DIGIT_W +: bcdas_pkg::DIGIT_W]);
            db[i] = bcdas_pkg::bcd_clamp(req.b_digits[i*bcdas_pkg::DIGIT_W +: bcdas_pkg::DIGIT_W]);
            dsum[i]         = {1'b0, da[i]} + {1'b0, db[i]};
            add_gp.gen[i]   = dsum[i] >= bcdas_pkg::DEC_RADIX;
            add_gp.prop[i]  = dsum[i] == {1'b0, bcdas_pkg::DEC_MAX};
            ab_gp.gen[i]    = da[i] < db[i];
            ab_gp.prop[i]   = da[i] == db[i];
            ba_gp.gen[i]    = db[i] < da[i];
            ba_gp.prop[i]   = da[i] == db[i];
        end
    end

    bcdas_prefix u_add_prefix (.gp(add_gp), .carry(add_c));
    bcdas_prefix u_ab_prefix  (.gp(ab_gp),  .carry(ab_b));
    bcdas_prefix u_ba_prefix  (.gp(ba_gp),  .carry(ba_b));

    always_comb
    begin
        logic [bcdas_pkg::DIGIT_W:0] t;
        add_r = '0;
        ab_r  = '0;
        ba_r  = '0;
        for (int i = 0; i < bcdas_pkg::DIGITS; i++)
        begin
            t = dsum[i] + {4'd0, add_c[i]};
            if (t >= bcdas_pkg::DEC_RADIX)
            begin
                t = t - bcdas_pkg::DEC_RADIX;
            end
            add_r[i*bcdas_pkg::DIGIT_W +: bcdas_pkg::DIGIT_W] = t[bcdas_pkg::DIGIT_W-1:0];

            t = {1'b0, da[i]} - {1'b0, db[i]} - {4'd0, ab_b[i]};
            if (t[bcdas_pkg::DIGIT_W])
            begin
                t = t + bcdas_pkg::DEC_RADIX;
            end
            ab_r[i*bcdas_pkg::DIGIT_W +: bcdas_pkg::DIGIT_W] = t[bcdas_pkg::DIGIT_W-1:0];

            t = {1'b0, db[i]} - {1'b0, da[i]} - {4'd0, ba_b[i]};
            if (t[bcdas_pkg::DIGIT_W])
            begin
                t = t + bcdas_pkg::DEC_RADIX;
            end
            ba_r[i*bcdas_pkg::DIGIT_W +: bcdas_pkg::DIGIT_W] = t[bcdas_pkg::DIGIT_W-1:0];
        end
    end

    assign b_neg_eff = req.b_negative ^ (req.cmd == bcdas_pkg::CMD_SUB);
    assign a_lt_b    = ab_b[bcdas_pkg::DIGITS];

    always_comb
    begin
        priority if (req.a_negative == b_neg_eff)
        begin
            rsp.result_digits   = add_r;
            rsp.result_negative = req.a_negative;
            rsp.overflow        = add_c[bcdas_pkg::DIGITS];
        end
        else if (a_lt_b)
        begin
            rsp.result_digits   = ba_r;
            rsp.result_negative = b_neg_eff;
            rsp.overflow        = 1'b0;
        end
        else
        begin
            rsp.result_digits   = ab_r;
            rsp.result_negative = req.a_negative;
            rsp.overflow        = 1'b0;
        end
    end

endmodule

// ----- rtl/bcd_signed_add_subtract_core.sv -----
// ---------------------------------------------------------------------------
// bcd_signed_add_subtract_core
// Sign-magnitude packed-BCD adder/subtractor with registered input and result.
// Pipeline: an accepted request passes through the input register, then the
//   result register, before its result can be taken.
// Throughput: one transaction per cycle unless rsp_stall holds the result; the path
//   is set by the digit lookahead carry network between the two registers.
// Reset: asynchronous, clears both valid flags; payload is not reset.
// ---------------------------------------------------------------------------
module bcd_signed_add_subtract_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  bcdas_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output bcdas_pkg::rsp_t rsp
);

    bcdas_pkg::req_t in_reg;
    logic            in_valid_reg;
    bcdas_pkg::rsp_t out_reg;
    bcdas_pkg::rsp_t out_next;
    logic            out_valid_reg;
    logic            out_ready;
    logic            in_ready;

    assign out_ready = !out_valid_reg || !rsp_stall;
    assign in_ready  = !in_valid_reg || out_ready;
    assign req_stall = !in_ready;

    bcdas_datapath u_datapath (.req(in_reg), .rsp(out_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= req_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && req_valid)
        begin
            in_reg <= req;
        end
        if (out_ready && in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (in_valid_reg && out_valid_reg && rsp_stall))
        else $error("input stalled while pipeline has room");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> in_valid_reg)
        else $error("accepted transaction not held in input register");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_ready) |=> out_valid_reg)
        else $error("transaction lost between input and result register");

    a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.result_digits >> (bcdas_pkg::DIGIT_W * bcdas_pkg::DIGITS)) == '0))
        else $error("result digits above width not zero");

endmodule
